// ===== sv/sts_pkg.sv =====
// Shared types and codes for the software timer scheduler.
// Used by sts_ctrl, sts_dp and software_timer_scheduler_core; no dependencies.
package sts_pkg;

  // input function codes
  localparam logic FUNC_SET     = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  // result kind codes
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REARM   = 1'b1;

  localparam int DELAY_W = 31;
  localparam int ID_W    = 4;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the input item
    logic remove;      // drop the addressed timer from the list
    logic scan_start;  // start counting entries due no later than the new deadline
    logic insert;      // place the new entry, rearm when it lands at the head
    logic pop;         // drop the head and report it expired
    logic rearm_head;  // report a rearm for the head deadline
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic id_bad;
    logic id_pending;
    logic full;
    logic empty;
    logic scan_busy;
    logic expired;
  } sts_t;

endpackage

// ===== sv/software_timer_scheduler_core.sv =====
// Software timer scheduler: up to TIMERS logical timers kept in deadline
// order behind one hardware timer. Depends on sts_pkg, sts_ctrl, sts_dp.
//
// Usage. Present an item on in_* and raise start; it is transferred at a
// rising edge with start high and busy low. in_func selects a set (0) or a
// service (1). Results appear on out_* for exactly one cycle with out_valid
// high; out_last marks the final result of an item. The receiver cannot
// stall, so results are simply taken as they come.
// Operation. A set reads every deadline slot once through the single memory
// read port to find the insertion place. A service reads each head deadline
// from memory before it is compared, for every expired timer and for the
// head that is rearmed. Ignored sets give no result.
// Results land on the edge where busy falls, or earlier for expiries.
// Reset. rst_n low clears all pending flags and the count; deadline memory
// and list contents are not cleared; reads of them are gated by the flags.
module software_timer_scheduler_core import sts_pkg::*; #(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [DELAY_W-1:0] in_timeout_ms,
  input  logic [47:0]        in_now_ms,
  output logic               out_valid,
  output logic               out_kind,
  output logic [ID_W-1:0]    out_expired_id,
  output logic [DELAY_W-1:0] out_delay_ms,
  output logic               out_last
);

  cmd_t cmd;
  sts_t sts;

  sts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  sts_dp #(
    .TIMERS    (TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_timer_id    (in_timer_id),
    .in_timeout_ms  (in_timeout_ms),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_expired_id (out_expired_id),
    .out_delay_ms   (out_delay_ms),
    .out_last       (out_last)
  );

endmodule

// ===== sv/sts_dp.sv =====
// Datapath of the timer scheduler: deadline memory, ordered id list, flags,
// insertion scan and result registers. Depends on sts_pkg.
module sts_dp import sts_pkg::*; #(
  parameter int TIMERS    = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [ID_W-1:0]      in_timer_id,
  input  logic [DELAY_W-1:0]   in_timeout_ms,
  input  logic [47:0]          in_now_ms,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [ID_W-1:0]      out_expired_id,
  output logic [DELAY_W-1:0]   out_delay_ms,
  output logic                 out_last
);

  localparam int IDW  = $clog2(TIMERS);
  localparam int CW   = $clog2(TIMERS + 1);
  localparam int SUMW = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] DMAX = TIME_BITS'({DELAY_W{1'b1}});

  // latched item
  logic [ID_W-1:0]      id_r;
  logic                 id_bad_r;
  logic [TIME_BITS-1:0] dl_r;
  logic [TIME_BITS-1:0] now_r;

  // list state
  logic [TIMERS-1:0]    pend_r;
  logic [IDW-1:0]       ord_r [TIMERS];
  logic [CW-1:0]        cnt_r;

  // deadline memory and scan
  logic [TIME_BITS-1:0] dmem [TIMERS];
  logic [TIME_BITS-1:0] rd_r;
  logic [IDW-1:0]       raddr;
  logic [CW-1:0]        sk_r;
  logic                 run_r;
  logic                 rvalid_r;
  logic [IDW-1:0]       ridx_r;
  logic [CW-1:0]        pos_r;

  // outputs
  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [ID_W-1:0]      out_id_r;
  logic [DELAY_W-1:0]   out_delay_r;
  logic                 out_last_r;

  logic [TIME_BITS-1:0] now_t;
  logic [SUMW-1:0]      sum;
  logic [IDW-1:0]       idx;
  logic [TIMERS-1:0]    match;
  logic [TIMERS-1:0]    rm_hot;
  logic [TIMERS-1:0]    rm_mask;
  logic [IDW-1:0]       rm_id;
  logic [TIME_BITS-1:0] ra_dl;
  logic [TIME_BITS-1:0] diff;
  logic [DELAY_W-1:0]   delay;

  assign now_t = TIME_BITS'(in_now_ms);
  assign sum   = SUMW'(now_t) + SUMW'(in_timeout_ms);
  assign idx   = IDW'(id_r);

  // position of the addressed id among the valid entries
  always_comb begin
    for (int i = 0; i < TIMERS; i++) begin
      match[i] = (ord_r[i] == idx) && (CW'(i) < cnt_r);
    end
  end

  // entries at and after the removed one shift down
  assign rm_hot  = cmd.pop ? TIMERS'(1) : match;
  assign rm_mask = ~(rm_hot - TIMERS'(1));
  assign rm_id   = cmd.pop ? ord_r[0] : idx;

  // rearm delay, clamped to 1 .. 2^31-1
  assign ra_dl = cmd.insert ? dl_r : rd_r;
  assign diff  = ra_dl - now_r;
  always_comb begin
    if (ra_dl <= now_r) begin
      delay = DELAY_W'(1);
    end else if (diff > DMAX) begin
      delay = {DELAY_W{1'b1}};
    end else begin
      delay = DELAY_W'(diff);
    end
  end

  assign raddr = run_r ? sk_r[IDW-1:0] : ord_r[0];

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    rd_r <= dmem[raddr];
    if (cmd.insert) begin
      dmem[idx] <= dl_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      run_r       <= 1'b0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.insert && pos_r == '0) || cmd.pop || cmd.rearm_head;
      rvalid_r    <= run_r;
      if (cmd.scan_start) begin
        run_r <= 1'b1;
      end else if (run_r && sk_r == CW'(TIMERS - 1)) begin
        run_r <= 1'b0;
      end
      if (cmd.remove || cmd.pop) begin
        pend_r[rm_id] <= 1'b0;
        cnt_r         <= cnt_r - CW'(1);
      end else if (cmd.insert) begin
        pend_r[idx] <= 1'b1;
        cnt_r       <= cnt_r + CW'(1);
      end
    end
  end

  // payload: item latch, scan counters, list and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r     <= in_timer_id;
      id_bad_r <= !(32'(in_timer_id) < TIMERS);
      now_r    <= now_t;
      dl_r     <= sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    end
    ridx_r <= sk_r[IDW-1:0];
    if (cmd.scan_start) begin
      sk_r  <= '0;
      pos_r <= '0;
    end else begin
      if (run_r) begin
        sk_r <= sk_r + CW'(1);
      end
      if (rvalid_r && pend_r[ridx_r] && rd_r <= dl_r) begin
        pos_r <= pos_r + CW'(1);
      end
    end
    // list shifts; neighbour indexes stay inside the array at the ends
    for (int i = 0; i < TIMERS; i++) begin
      if (cmd.remove || cmd.pop) begin
        if (rm_mask[i] && i < TIMERS - 1) begin
          ord_r[i] <= ord_r[(i < TIMERS - 1) ? i + 1 : i];
        end
      end else if (cmd.insert) begin
        if (CW'(i) == pos_r) begin
          ord_r[i] <= idx;
        end else if (CW'(i) > pos_r && i > 0) begin
          ord_r[i] <= ord_r[(i > 0) ? i - 1 : i];
        end
      end
    end
    // result
    out_kind_r  <= cmd.pop ? KIND_EXPIRED : KIND_REARM;
    out_id_r    <= cmd.pop ? ID_W'(ord_r[0]) : '0;
    out_delay_r <= cmd.pop ? '0 : delay;
    out_last_r  <= cmd.pop ? (cnt_r == CW'(1)) : 1'b1;
  end

  assign sts.id_bad     = id_bad_r;
  assign sts.id_pending = pend_r[idx];
  assign sts.full       = (cnt_r == CW'(TIMERS));
  assign sts.empty      = (cnt_r == '0);
  assign sts.scan_busy  = run_r || rvalid_r;
  assign sts.expired    = (rd_r <= now_r);

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_expired_id = out_id_r;
  assign out_delay_ms   = out_delay_r;
  assign out_last       = out_last_r;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TIMERS))
    else $error("pending count beyond capacity");
  a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_r) == int'(cnt_r))
    else $error("pending flags disagree with count");
  a_rearm_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REARM |-> out_last && out_delay_ms != '0)
    else $error("rearm not last or zero delay");

endmodule

// ===== sv/sts_ctrl.sv =====
// Controller state machine of the timer scheduler: sequences set and service
// items through the datapath by command and status. Depends on sts_pkg.
module sts_ctrl import sts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_func,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SET_CHK, S_SET_SCAN, S_SET_WAIT, S_SET_INS, S_SVC_RD, S_SVC_CHK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_SERVICE) ? S_SVC_RD : S_SET_CHK;
        end
      end
      S_SET_CHK: begin
        if (sts.id_bad) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.remove = sts.id_pending;
          state_nxt  = (sts.full && !sts.id_pending) ? S_IDLE : S_SET_SCAN;
        end
      end
      S_SET_SCAN: begin
        cmd.scan_start = 1'b1;
        state_nxt      = S_SET_WAIT;
      end
      S_SET_WAIT: begin
        if (!sts.scan_busy) begin
          state_nxt = S_SET_INS;
        end
      end
      S_SET_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SVC_RD: begin
        state_nxt = sts.empty ? S_IDLE : S_SVC_CHK;
      end
      S_SVC_CHK: begin
        if (sts.expired) begin
          cmd.pop   = 1'b1;
          state_nxt = S_SVC_RD;
        end else begin
          cmd.rearm_head = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== verif/sts_scoreboard.sv =====
`timescale 1ns / 1ps
// Timer list predictor and result checker for the software timer scheduler.
// Depends on sts_pkg for the function and kind codes.
import sts_pkg::*;

class sts_scoreboard;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic               last;
  } sched_result_t;

  logic [47:0]   deadline [16];
  bit            armed [16];
  logic [3:0]    order_q [$];
  sched_result_t due_q [$];
  int            n_bad;
  int            n_checked;
  int            n_expiries;
  int            n_rearms;

  function logic [DELAY_W-1:0] clamp_delay(logic [47:0] dl, logic [47:0] now);
    logic [47:0] d;
    d = (dl > now) ? dl - now : 48'd0;
    if (d < 1) d = 1;
    if (d > 48'h7FFF_FFFF) d = 48'h7FFF_FFFF;
    return d[DELAY_W-1:0];
  endfunction

  function void drop_id(logic [3:0] id);
    foreach (order_q[p]) begin
      if (order_q[p] == id) begin
        order_q.delete(p);
        break;
      end
    end
    armed[id] = 0;
  endfunction

  // work out the results of one accepted input transfer
  function void note_item(logic func, logic [3:0] id, logic [30:0] tmo, logic [47:0] now);
    logic [48:0]   sum;
    logic [47:0]   dl;
    int            pos;
    int            n;
    sched_result_t r;
    n = 0;
    if (func == FUNC_SET) begin
      sum = {1'b0, now} + tmo;
      dl = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      if (armed[id]) drop_id(id);
      pos = 0;
      while (pos < order_q.size() && deadline[order_q[pos]] <= dl) pos++;
      order_q.insert(pos, id);
      deadline[id] = dl;
      armed[id] = 1;
      if (pos == 0) begin
        r = '{KIND_REARM, '0, clamp_delay(dl, now), 1'b0};
        due_q.push_back(r);
        n++;
      end
    end else begin
      while (order_q.size() > 0 && deadline[order_q[0]] <= now) begin
        r = '{KIND_EXPIRED, order_q[0], '0, 1'b0};
        drop_id(order_q[0]);
        due_q.push_back(r);
        n++;
      end
      if (order_q.size() > 0) begin
        r = '{KIND_REARM, '0, clamp_delay(deadline[order_q[0]], now), 1'b0};
        due_q.push_back(r);
        n++;
      end
    end
    if (n > 0) due_q[$].last = 1'b1;
  endfunction

  function void check_result(sched_result_t got);
    sched_result_t want;
    n_checked++;
    if (got.kind == KIND_EXPIRED) n_expiries++;
    else n_rearms++;
    if (due_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10) $display("ERROR: result mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench for software_timer_scheduler_core: directed and random
// set/service transfers checked against sts_scoreboard. Depends on sts_pkg.
module tb import sts_pkg::*; ();

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_func;
  logic [ID_W-1:0]    in_timer_id;
  logic [DELAY_W-1:0] in_timeout_ms;
  logic [47:0]        in_now_ms;
  logic               out_valid;
  logic               out_kind;
  logic [ID_W-1:0]    out_expired_id;
  logic [DELAY_W-1:0] out_delay_ms;
  logic               out_last;

  sts_scoreboard sched_sb;
  int            idle_pct;
  logic [47:0]   clock_ms;
  int            n_items;

  software_timer_scheduler_core u_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // results cannot be held off: take each one on its strobe
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sched_sb.check_result('{out_kind, out_expired_id, out_delay_ms, out_last});
  end

  // one input transfer, with a random idle gap before it; the block stays
  // busy for the edge after a transfer, so waiting it out costs nothing
  task automatic send_item(logic func, logic [3:0] id, logic [30:0] tmo, logic [47:0] now);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start         <= 1'b1;
    in_func       <= func;
    in_timer_id   <= id;
    in_timeout_ms <= tmo;
    in_now_ms     <= now;
    do @(posedge clk); while (busy);
    sched_sb.note_item(func, id, tmo, now);
    start <= 1'b0;
    n_items++;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (sched_sb.due_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // mostly small timeouts and a slowly advancing clock so expiries happen
  task automatic random_item();
    logic [30:0] tmo;
    case ($urandom_range(9))
      0:       tmo = 31'($urandom);
      1:       tmo = 31'h7FFF_FFFF - 31'($urandom_range(3));
      default: tmo = 31'($urandom_range(200));
    endcase
    if ($urandom_range(2) == 0) begin
      clock_ms = clock_ms + 48'($urandom_range(120));
      send_item(FUNC_SERVICE, 4'($urandom), 31'($urandom), clock_ms);
    end else begin
      send_item(FUNC_SET, 4'($urandom), tmo, clock_ms);
    end
  endtask

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sched_sb = new();
    rst_n = 1'b0; start = 1'b0; in_func = FUNC_SET; in_timer_id = '0;
    in_timeout_ms = '0; in_now_ms = '0;
    idle_pct = 0; n_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty service, zero timeout, reschedule, equal deadlines,
    // saturating deadline, far-off rearm clamp, all-ones clock
    send_item(FUNC_SERVICE, 4'hF, 31'h7FFF_FFFF, 48'd0);
    send_item(FUNC_SET, 4'd0, 31'd0, 48'd100);
    send_item(FUNC_SET, 4'd1, 31'd50, 48'd100);
    send_item(FUNC_SET, 4'd2, 31'd50, 48'd100);
    send_item(FUNC_SET, 4'd0, 31'd10, 48'd100);
    send_item(FUNC_SET, 4'd1, 31'd5, 48'd100);
    send_item(FUNC_SET, 4'd15, 31'h7FFF_FFFF, 48'd100);
    send_item(FUNC_SERVICE, 4'd0, 31'd0, 48'd99);
    send_item(FUNC_SERVICE, 4'd0, 31'd0, 48'd150);
    send_item(FUNC_SET, 4'd3, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFF0);
    send_item(FUNC_SET, 4'd4, 31'd7, 48'hFFFF_FFFF_FFFF);
    send_item(FUNC_SET, 4'd5, 31'h5555_5555, 48'hAAAA_AAAA_AAAA);
    send_item(FUNC_SERVICE, 4'd0, 31'd0, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 16; i++)
      send_item(FUNC_SET, i[3:0], 31'd1000 - i[30:0], 48'd0);
    send_item(FUNC_SERVICE, 4'd0, 31'd0, 48'd2000);
    drain_results();

    // random phases with different sender idling
    clock_ms = 48'd0;
    idle_pct = 10;
    repeat (100) random_item();
    drain_results();
    idle_pct = 81;
    repeat (100) random_item();
    drain_results();
    idle_pct = 0;
    repeat (100) random_item();
    drain_results();

    $display("Ran %0d transfers: %0d results checked (%0d expiries, %0d rearms).",
             n_items, sched_sb.n_checked, sched_sb.n_expiries, sched_sb.n_rearms);
    if (sched_sb.n_bad == 0 && sched_sb.due_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
